[rtl/core/avr_pkg.sv]
// Shared constants, types and the CORDIC arctangent table for the axis-angle rotator.
package avr_pkg;

  localparam int DATA_BITS   = 16;
  localparam int ANGLE_BITS  = 16;
  localparam int AXIS_BITS   = 16;
  localparam int CORDIC_ITERS = 20;
  localparam int CW          = 34;             // CORDIC datapath width
  localparam int IDX_BITS    = $clog2(CORDIC_ITERS);
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef logic signed [DATA_BITS-1:0]  data_t;
  typedef logic signed [AXIS_BITS-1:0]  axis_t;
  typedef logic        [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [CW-1:0]         cw_t;

  // One word travelling through the row of CORDIC cells.
  typedef struct packed {
    logic  valid;
    logic  flip;
    cw_t   x;
    cw_t   y;
    cw_t   z;
    data_t vx;
    data_t vy;
    data_t vz;
    axis_t kx;
    axis_t ky;
    axis_t kz;
  } cell_t;

  // Arctangent of 2^-i in units where 2^32 is one turn.
  function automatic cw_t atan_turns(input logic [IDX_BITS-1:0] i);
    cw_t a;
    case (i)
      5'd0:    a = CW'(536870912);
      5'd1:    a = CW'(316933406);
      5'd2:    a = CW'(167458907);
      5'd3:    a = CW'(85004756);
      5'd4:    a = CW'(42667331);
      5'd5:    a = CW'(21354465);
      5'd6:    a = CW'(10679838);
      5'd7:    a = CW'(5340245);
      5'd8:    a = CW'(2670163);
      5'd9:    a = CW'(1335087);
      5'd10:   a = CW'(667544);
      5'd11:   a = CW'(333772);
      5'd12:   a = CW'(166886);
      5'd13:   a = CW'(83443);
      5'd14:   a = CW'(41721);
      5'd15:   a = CW'(20860);
      5'd16:   a = CW'(10430);
      5'd17:   a = CW'(5215);
      5'd18:   a = CW'(2608);
      5'd19:   a = CW'(1304);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/avr_if.sv]
// Valid/ready channel interfaces for the rotator input and result words.
interface avr_in_if;
  logic              valid;
  logic              ready;
  avr_pkg::angle_t   angle;
  avr_pkg::data_t    vec_x;
  avr_pkg::data_t    vec_y;
  avr_pkg::data_t    vec_z;
  avr_pkg::axis_t    axis_x;
  avr_pkg::axis_t    axis_y;
  avr_pkg::axis_t    axis_z;
  modport source (output valid, angle, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  input ready);
  modport sink (input valid, angle, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                output ready);
endinterface

interface avr_out_if;
  logic           valid;
  logic           ready;
  avr_pkg::data_t out_x;
  avr_pkg::data_t out_y;
  avr_pkg::data_t out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

[rtl/core/avr_cordic_cell.sv]
// One rotation-mode CORDIC iteration cell of the sine/cosine row.
module avr_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [avr_pkg::IDX_BITS-1:0] idx,
  input  avr_pkg::cell_t               d_in,
  output avr_pkg::cell_t               d_out
);
  avr_pkg::cell_t q_r, q_nxt;
  avr_pkg::cw_t   dx, dy, at;

  always_comb begin
    dx    = d_in.y >>> idx;
    dy    = d_in.x >>> idx;
    at    = avr_pkg::atan_turns(idx);
    q_nxt = d_in;
    if (!d_in.z[avr_pkg::CW-1]) begin
      q_nxt.x = d_in.x - dx;
      q_nxt.y = d_in.y + dy;
      q_nxt.z = d_in.z - at;
    end else begin
      q_nxt.x = d_in.x + dx;
      q_nxt.y = d_in.y - dy;
      q_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

[rtl/core/avr_matrix.sv]
// Builds the Rodrigues matrix from sine and cosine and applies it to the vector.
module avr_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  avr_pkg::cell_t d_in,
  output logic           out_valid,
  output avr_pkg::data_t out_x,
  output avr_pkg::data_t out_y,
  output avr_pkg::data_t out_z
);
  typedef logic signed [27:0] cs_t;
  typedef logic signed [31:0] kk_t;
  typedef logic signed [35:0] rm_t;
  typedef logic signed [51:0] pr_t;

  // Stage A: cosine, sine and axis products.
  logic               va_r;
  cs_t                c_a_r, s_a_r;
  kk_t                kk_a_r [6];
  avr_pkg::axis_t     k_a_r  [3];
  avr_pkg::data_t     v_a_r  [3];
  avr_pkg::cw_t       xs, ys;
  // Stage B: outer-product and cross-product terms.
  logic               vb_r;
  cs_t                c_b_r;
  logic signed [33:0] p_b_r [6];
  logic signed [29:0] s_b_r [3];
  avr_pkg::data_t     v_b_r [3];
  logic signed [28:0] omc;
  logic signed [60:0] pw [6];
  logic signed [43:0] sw [3];
  // Stage C: matrix entries.
  logic               vc_r;
  rm_t                r_c_r [9];
  avr_pkg::data_t     v_c_r [3];
  // Stage D: element products.
  logic               vd_r;
  pr_t                m_d_r [9];
  // Stage E: output register.
  logic               ve_r;
  avr_pkg::data_t     o_r [3];
  logic signed [53:0] acc [3];
  logic signed [29:0] rq  [3];
  avr_pkg::data_t     o_nxt [3];

  localparam logic signed [29:0] OMAX = 30'((1 <<< (avr_pkg::DATA_BITS-1)) - 1);
  localparam logic signed [29:0] OMIN = -30'(1 <<< (avr_pkg::DATA_BITS-1));

  always_comb begin
    xs = d_in.flip ? -d_in.x : d_in.x;
    ys = d_in.flip ? -d_in.y : d_in.y;
    omc = 29'sd16777216 - 29'(c_a_r);
    for (int i = 0; i < 6; i++) begin
      pw[i] = kk_a_r[i] * omc;
    end
    for (int i = 0; i < 3; i++) begin
      sw[i] = k_a_r[i] * s_a_r;
    end
    for (int i = 0; i < 3; i++) begin
      acc[i] = 54'(m_d_r[3*i]) + 54'(m_d_r[3*i+1]) + 54'(m_d_r[3*i+2]);
      rq[i]  = 30'((acc[i] + 54'sd8388608) >>> 24);
      if (rq[i] > OMAX) begin
        o_nxt[i] = avr_pkg::DATA_BITS'(OMAX);
      end else if (rq[i] < OMIN) begin
        o_nxt[i] = avr_pkg::DATA_BITS'(OMIN);
      end else begin
        o_nxt[i] = avr_pkg::DATA_BITS'(rq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= d_in.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a_r     <= 28'((xs + 34'sd32) >>> 6);
      s_a_r     <= 28'((ys + 34'sd32) >>> 6);
      kk_a_r[0] <= d_in.kx * d_in.kx;
      kk_a_r[1] <= d_in.ky * d_in.ky;
      kk_a_r[2] <= d_in.kz * d_in.kz;
      kk_a_r[3] <= d_in.kx * d_in.ky;
      kk_a_r[4] <= d_in.kx * d_in.kz;
      kk_a_r[5] <= d_in.ky * d_in.kz;
      k_a_r[0]  <= d_in.kx;
      k_a_r[1]  <= d_in.ky;
      k_a_r[2]  <= d_in.kz;
      v_a_r[0]  <= d_in.vx;
      v_a_r[1]  <= d_in.vy;
      v_a_r[2]  <= d_in.vz;

      c_b_r <= c_a_r;
      for (int i = 0; i < 6; i++) begin
        p_b_r[i] <= 34'((pw[i] + 61'sd134217728) >>> 28);
      end
      for (int i = 0; i < 3; i++) begin
        s_b_r[i] <= 30'((sw[i] + 44'sd8192) >>> 14);
        v_b_r[i] <= v_a_r[i];
      end

      // Order of terms: xx, yy, zz, xy, xz, yz and Sx, Sy, Sz.
      r_c_r[0] <= 36'(c_b_r) + 36'(p_b_r[0]);
      r_c_r[1] <= 36'(p_b_r[3]) - 36'(s_b_r[2]);
      r_c_r[2] <= 36'(p_b_r[4]) + 36'(s_b_r[1]);
      r_c_r[3] <= 36'(p_b_r[3]) + 36'(s_b_r[2]);
      r_c_r[4] <= 36'(c_b_r) + 36'(p_b_r[1]);
      r_c_r[5] <= 36'(p_b_r[5]) - 36'(s_b_r[0]);
      r_c_r[6] <= 36'(p_b_r[4]) - 36'(s_b_r[1]);
      r_c_r[7] <= 36'(p_b_r[5]) + 36'(s_b_r[0]);
      r_c_r[8] <= 36'(c_b_r) + 36'(p_b_r[2]);
      for (int i = 0; i < 3; i++) begin
        v_c_r[i] <= v_b_r[i];
      end

      for (int i = 0; i < 9; i++) begin
        m_d_r[i] <= r_c_r[i] * v_c_r[i % 3];
      end

      for (int i = 0; i < 3; i++) begin
        o_r[i] <= o_nxt[i];
      end
    end
  end

  assign out_valid = ve_r;
  assign out_x     = o_r[0];
  assign out_y     = o_r[1];
  assign out_z     = o_r[2];
endmodule

[rtl/core/axis_angle_vector_rotate.sv]
// Top level of the fixed-point Rodrigues axis-angle vector rotator.
//
// Usage: each word on the input channel (in_s) carries an angle in binary
// angle units (65536 is one turn), a Q8.8 vector and a Q1.14 axis. The axis
// is used as given. Each input word yields exactly one result word on the
// output channel (out_s) holding the rotated Q8.8 vector, rounded and
// saturated to the 16-bit range.
// Sine and cosine come from a row of 20 CORDIC cells, one iteration per
// cell, each passing its word on every cycle the pipeline advances. Five
// more register stages form the matrix and the matrix-vector product.
// The result word passes through 25 register stages, the first loaded by
// the edge that accepts the input word, and one word is accepted every
// cycle while the receiver keeps taking results.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, every stage holds and in_s.ready drops, so nothing is
// lost or repeated; the input side keeps flowing while the output register
// is empty or being drained in the same cycle.
// A synchronous active-low reset clears all stage valid bits; the data
// registers are not reset.
module axis_angle_vector_rotate (
  input  logic      clk,
  input  logic      rst_n,
  avr_in_if.sink    in_s,
  avr_out_if.source out_s
);
  localparam int N = avr_pkg::CORDIC_ITERS;

  logic           en;
  logic           o_valid;
  logic [31:0]    a32;
  logic [31:0]    r32;
  logic           flip;
  avr_pkg::cell_t chain [N+1];

  // Whole-pipeline advance: move when the output register is empty or taken.
  assign en         = !o_valid || out_s.ready;
  assign in_s.ready = en;

  // Quadrant reduction: angles in [90, 270) degrees are turned by half a
  // turn and the CORDIC outputs negated later.
  always_comb begin
    a32  = {in_s.angle, (32-avr_pkg::ANGLE_BITS)'(0)};
    flip = a32[31] ^ a32[30];
    r32  = flip ? (a32 ^ 32'h8000_0000) : a32;
    chain[0].valid = in_s.valid;
    chain[0].flip  = flip;
    chain[0].x     = avr_pkg::CORDIC_GAIN;
    chain[0].y     = '0;
    chain[0].z     = avr_pkg::CW'($signed(r32));
    chain[0].vx    = in_s.vec_x;
    chain[0].vy    = in_s.vec_y;
    chain[0].vz    = in_s.vec_z;
    chain[0].kx    = in_s.axis_x;
    chain[0].ky    = in_s.axis_y;
    chain[0].kz    = in_s.axis_z;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .idx  (avr_pkg::IDX_BITS'(i)),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  avr_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d_in     (chain[N]),
    .out_valid(o_valid),
    .out_x    (out_s.out_x),
    .out_y    (out_s.out_y),
    .out_z    (out_s.out_z)
  );

  assign out_s.valid = o_valid;
endmodule

[rtl/core/avr_checker.sv]
// Port-level checker for the rotator, bound to the top level.
module avr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input avr_pkg::data_t out_x,
  input avr_pkg::data_t out_y,
  input avr_pkg::data_t out_z
);
  // A result that is held back stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result word changed while stalled");

  // A stalled receiver with a result waiting blocks the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is stalled");

  // No result appears right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind axis_angle_vector_rotate avr_checker u_avr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_s.ready),
  .out_valid(out_s.valid),
  .out_ready(out_s.ready),
  .out_x    (out_s.out_x),
  .out_y    (out_s.out_y),
  .out_z    (out_s.out_z)
);
